/* rtl/ps2_mouse_packet_decoder_top_macros.svh */
// Assertion macros used by the checker file of the PS/2 mouse decoder.
`ifndef PS2_MOUSE_PACKET_DECODER_TOP_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define PS2MD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define PS2MD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define PS2MD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ps2md_pkg.sv */
package ps2md_pkg;

  localparam logic [1:0] MODE_STANDARD    = 2'd0;
  localparam logic [1:0] MODE_WHEEL       = 2'd1;
  localparam logic [1:0] MODE_FIVE_BUTTON = 2'd2;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // One complete packet that passed the flags check.
  typedef struct packed {
    logic [7:0] flags;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    logic [7:0] extra_byte;
    logic [1:0] mode;
  } packet_t;

endpackage

/* rtl/ps2md_front.sv */
module ps2md_front import ps2md_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       queue_full,
  output logic       push,
  output packet_t    push_packet
);

  logic [1:0] packet_mode;
  logic [1:0] byte_count;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic       four_byte;
  logic       complete;
  logic       accept;
  logic       keep;

  assign in_stall  = queue_full;
  assign accept    = in_valid && !queue_full;
  assign four_byte = (packet_mode == MODE_WHEEL) || (packet_mode == MODE_FIVE_BUTTON);
  // In standard mode a count of three can only follow a mode change; the
  // packet then completes from the three held bytes.
  assign complete  = four_byte ? (byte_count == 2'd3) : (byte_count >= 2'd2);
  assign keep      = byte0[3] && (byte0[7:6] == 2'b00);

  always_comb begin
    push_packet.flags      = byte0;
    push_packet.x_byte     = byte1;
    push_packet.y_byte     = (byte_count == 2'd2) ? rx_byte : byte2;
    push_packet.extra_byte = rx_byte;
    push_packet.mode       = packet_mode;
  end

  assign push = accept && complete && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_mode <= MODE_STANDARD;
      byte_count  <= 2'd0;
      byte0       <= 8'd0;
      byte1       <= 8'd0;
      byte2       <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        packet_mode <= cfg_wr_data;
      end
      if (accept) begin
        if (complete) begin
          byte_count <= 2'd0;
        end else begin
          byte_count <= byte_count + 2'd1;
          unique case (byte_count)
            2'd0:    byte0 <= rx_byte;
            2'd1:    byte1 <= rx_byte;
            default: byte2 <= rx_byte;
          endcase
        end
      end
    end
  end

endmodule

/* rtl/ps2md_queue.sv */
module ps2md_queue import ps2md_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  packet_t push_packet,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output packet_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  packet_t            entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_packet;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/ps2md_back.sv */
module ps2md_back import ps2md_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  packet_t           q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [4:0]        buttons,
  output logic signed [8:0] dx,
  output logic signed [9:0] dy,
  output logic signed [7:0] wheel
);

  logic [4:0] buttons_next;
  logic [8:0] dx_next;
  logic [9:0] dy_next;
  logic [7:0] wheel_next;
  logic [9:0] y_ext;
  logic       load;

  assign load = !out_valid || !out_stall;
  assign pop  = load && q_not_empty;

  always_comb begin
    buttons_next = {2'b00, q_head.flags[2:0]};
    dx_next      = {q_head.flags[4], q_head.x_byte};
    y_ext        = {{2{q_head.flags[5]}}, q_head.y_byte};
    dy_next      = 10'd0 - y_ext;
    wheel_next   = 8'd0;
    unique case (q_head.mode)
      MODE_WHEEL: begin
        wheel_next = q_head.extra_byte;
      end
      MODE_FIVE_BUTTON: begin
        wheel_next   = {{4{q_head.extra_byte[3]}}, q_head.extra_byte[3:0]};
        buttons_next = {q_head.extra_byte[5], q_head.extra_byte[4], q_head.flags[2:0]};
      end
      default: begin
        wheel_next = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buttons <= buttons_next;
      dx      <= dx_next;
      dy      <= dy_next;
      wheel   <= wheel_next;
    end
  end

endmodule

/* rtl/ps2_mouse_packet_decoder_top.sv */
// PS/2 mouse packet decoder.
// Input channel: one mouse byte per transaction on rx_byte, handshake in_valid and
// in_stall. Output channel: one decoded packet per transaction (buttons, dx, dy,
// wheel), handshake out_valid and out_stall. The packet format is set by writing
// packet_mode through cfg_wr_en and cfg_wr_data while the block is idle.
// A byte is taken every cycle unless in_stall is high. Packets whose flags byte
// lacks bit 3 or carries an overflow bit produce no output transaction.
// A finished packet is written into the queue at the edge that takes its last byte;
// it moves on into the output register when that register is empty or not stalled.
// Throughput: one byte per cycle while in_stall is low; the queue between front and
// back holds QUEUE_DEPTH finished packets.
// When the receiver stalls, the output register holds its transaction, the queue
// fills, and in_stall rises only when the queue is full.
// Reset (synchronous, active high) selects standard three-byte mode, clears the
// byte count, empties the queue and drops any pending output. No clearing pass
// is needed; the block accepts bytes as soon as reset is released.
module ps2_mouse_packet_decoder_top import ps2md_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [4:0]        buttons,
  output logic signed [8:0] dx,
  output logic signed [9:0] dy,
  output logic signed [7:0] wheel
);

  logic    push;
  packet_t push_packet;
  logic    queue_full;
  logic    q_not_empty;
  packet_t q_head;
  logic    pop;

  ps2md_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .queue_full  (queue_full),
    .push        (push),
    .push_packet (push_packet)
  );

  ps2md_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_packet (push_packet),
    .pop         (pop),
    .full        (queue_full),
    .not_empty   (q_not_empty),
    .head        (q_head)
  );

  ps2md_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .buttons     (buttons),
    .dx          (dx),
    .dy          (dy),
    .wheel       (wheel)
  );

endmodule

/* rtl/ps2md_checker.sv */
`include "ps2_mouse_packet_decoder_top_macros.svh"

module ps2md_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [4:0]        buttons,
  input logic signed [8:0] dx,
  input logic signed [9:0] dy,
  input logic signed [7:0] wheel
);

  // A held output transaction keeps its valid and its payload.
  `PS2MD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(buttons) && $stable(dx) && $stable(dy) && $stable(wheel), "stalled output changed")

  // Reset drops any pending output transaction.
  `PS2MD_ASSERT_ALWAYS_NEXT(a_reset_clears, clk, rst, !out_valid, "output valid after reset")

  // The queue can only be full while the output register is occupied.
  `PS2MD_ASSERT_IMPL(a_stall_needs_output, clk, rst, in_stall, out_valid, "input stalled with empty output")

  // A negated nine-bit value never reaches -256 or below.
  `PS2MD_ASSERT_IMPL(a_dy_range, clk, rst, out_valid, (dy[9:8] != 2'b10) && (dy != 10'sh300), "dy out of range")

endmodule

bind ps2_mouse_packet_decoder_top ps2md_checker u_checker (.*);

/* test/tb_ps2_mouse_packet_decoder_top.sv */
module tb_ps2_mouse_packet_decoder_top;
  import ps2md_pkg::*;

  // Encoding 3 is not a defined format; the block treats it as standard mode.
  localparam logic [1:0] MODE_UNDEFINED = 2'd3;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int BYTES_PER_PHASE = 48;

  typedef struct packed {
    logic [4:0]        buttons;
    logic signed [8:0] dx;
    logic signed [9:0] dy;
    logic signed [7:0] wheel;
  } mouse_report_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_wr_data = 2'd0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte = 8'd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [4:0]        buttons;
  logic signed [8:0] dx;
  logic signed [9:0] dy;
  logic signed [7:0] wheel;

  // Model of the decoder state, updated on each accepted byte and mode write.
  logic [1:0]    mode_now = MODE_STANDARD;
  int            held_count = 0;
  logic [7:0]    held [3] = '{default: 8'd0};
  mouse_report_t report_q [$];

  bit calm_run = 1'b0;
  int mismatches = 0;
  int bytes_sent = 0;
  int reports_seen = 0;
  int packets_dropped = 0;
  int mode_writes = 0;
  int quiet_cycles = 0;

  ps2_mouse_packet_decoder_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .buttons     (buttons),
    .dx          (dx),
    .dy          (dy),
    .wheel       (wheel)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Collects one byte and, when it completes a valid packet, queues the report.
  function automatic void absorb_byte(input logic [7:0] b);
    logic [7:0]        pkt [4];
    logic [7:0]        flags;
    logic signed [9:0] y_ext;
    int                need;
    mouse_report_t     r;
    need = (mode_now == MODE_WHEEL || mode_now == MODE_FIVE_BUTTON) ? 4 : 3;
    if (held_count + 1 < need) begin
      held[held_count] = b;
      held_count++;
      return;
    end
    pkt[0] = held[0];
    pkt[1] = held[1];
    pkt[2] = held[2];
    pkt[3] = b;
    // With three bytes held in standard mode the new byte is not used at all.
    if (held_count < 3) pkt[held_count] = b;
    held_count = 0;
    flags = pkt[0];
    if (!flags[3] || flags[7:6] != 2'b00) begin
      packets_dropped++;
      return;
    end
    r.buttons = {2'b00, flags[2:0]};
    r.dx = {flags[4], pkt[1]};
    y_ext = {{2{flags[5]}}, pkt[2]};
    r.dy = -y_ext;
    r.wheel = 8'sd0;
    if (mode_now == MODE_WHEEL) begin
      r.wheel = pkt[3];
    end else if (mode_now == MODE_FIVE_BUTTON) begin
      r.wheel = {{4{pkt[3][3]}}, pkt[3][3:0]};
      r.buttons[3] = pkt[3][4];
      r.buttons[4] = pkt[3][5];
    end
    report_q.push_back(r);
  endfunction

  always @(posedge clk) begin
    out_stall <= calm_run ? 1'b0 : ($urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin
    mouse_report_t want;
    if (!rst && out_valid && !out_stall) begin
      reports_seen++;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: buttons=%h dx=%0d dy=%0d wheel=%0d",
                   buttons, dx, dy, wheel);
      end else begin
        want = report_q.pop_front();
        if (buttons !== want.buttons || dx !== want.dx || dy !== want.dy ||
            wheel !== want.wheel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report mismatch: expected buttons=%h dx=%0d dy=%0d wheel=%0d, got buttons=%h dx=%0d dy=%0d wheel=%0d",
                     want.buttons, want.dx, want.dy, want.wheel, buttons, dx, dy, wheel);
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL ps2_mouse_packet_decoder_top");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm_run && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_byte(b);
    bytes_sent++;
  endtask

  // Holds the sender until every queued report is out and the pipeline is empty.
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain_reports();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_now = m;
    mode_writes++;
  endtask

  task automatic send_packet(input logic [7:0] flags, input logic [7:0] x,
                             input logic [7:0] y, input logic [7:0] extra);
    send_byte(flags);
    send_byte(x);
    send_byte(y);
    if (mode_now == MODE_WHEEL || mode_now == MODE_FIVE_BUTTON) send_byte(extra);
  endtask

  task automatic test_standard_packets();
    write_mode(MODE_STANDARD);
    send_packet(8'h3F, 8'hFF, 8'hFF, 8'h00);
    send_packet(8'h38, 8'h00, 8'h00, 8'h00);
    send_packet(8'hC8, 8'h12, 8'h34, 8'h00);
    send_packet(8'h07, 8'h56, 8'h78, 8'h00);
  endtask

  task automatic test_wheel_packets();
    write_mode(MODE_WHEEL);
    send_packet(8'h09, 8'h7F, 8'h80, 8'h80);
  endtask

  task automatic test_five_button_packets();
    write_mode(MODE_FIVE_BUTTON);
    send_packet(8'h0A, 8'h00, 8'h01, 8'hF8);
    send_packet(8'h08, 8'h80, 8'h7F, 8'h17);
  endtask

  task automatic test_undefined_mode();
    write_mode(MODE_UNDEFINED);
    send_packet(8'h0D, 8'h21, 8'hE0, 8'h00);
  endtask

  // Three bytes held in wheel mode, then standard mode: the next byte
  // finishes the packet from the held bytes.
  task automatic test_mode_switch_mid_packet();
    write_mode(MODE_WHEEL);
    send_byte(8'h0C);
    send_byte(8'h05);
    send_byte(8'hFB);
    write_mode(MODE_STANDARD);
    send_byte(8'h99);
  endtask

  task automatic test_random_traffic();
    logic [1:0] phase_mode [8];
    logic [7:0] flags;
    int         sent_start;
    phase_mode = '{MODE_WHEEL, MODE_FIVE_BUTTON, MODE_STANDARD, MODE_UNDEFINED,
                   MODE_FIVE_BUTTON, MODE_WHEEL, MODE_STANDARD, 2'd0};
    phase_mode[7] = 2'($urandom_range(0, 3));
    for (int p = 0; p < 8; p++) begin
      write_mode(phase_mode[p]);
      calm_run = (p == 3);
      sent_start = bytes_sent;
      while (bytes_sent - sent_start < BYTES_PER_PHASE) begin
        if (p == 5 && bytes_sent - sent_start >= BYTES_PER_PHASE / 2 &&
            bytes_sent - sent_start < BYTES_PER_PHASE / 2 + 4)
          drain_reports();
        if ($urandom_range(0, 99) < 8) begin
          // A stray byte shifts the framing of the packets that follow.
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          flags = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 99) < 80) flags = (flags | 8'h08) & 8'h3F;
          send_packet(flags, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
      end
      calm_run = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_standard_packets();
    test_wheel_packets();
    test_five_button_packets();
    test_undefined_mode();
    test_mode_switch_mid_packet();
    test_random_traffic();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d mouse bytes in all four mode encodings with %0d mode writes.",
             bytes_sent, mode_writes);
    $display("Checked %0d reports; %0d packets were dropped by the flags check.",
             reports_seen, packets_dropped);
    if (mismatches == 0) begin
      $display("PASS ps2_mouse_packet_decoder_top");
    end else begin
      $display("%0d mismatching reports.", mismatches);
      $display("FAIL ps2_mouse_packet_decoder_top");
    end
    $finish;
  end

endmodule

/* ps2_mouse_packet_decoder_top.f */
+incdir+rtl
rtl/ps2md_pkg.sv
rtl/ps2md_front.sv
rtl/ps2md_queue.sv
rtl/ps2md_back.sv
rtl/ps2_mouse_packet_decoder_top.sv
rtl/ps2md_checker.sv
test/tb_ps2_mouse_packet_decoder_top.sv
